>>> src/pmn_pkg.sv
package pmn_pkg;

   localparam int FIELD_COUNT = 8;
   localparam int PROB_W      = 16;
   localparam int POS_W       = 15;
   localparam int SUM_W       = 18;
   localparam int NORM_W      = 16;
   localparam int COUNT_W     = 4;
   localparam int CSR_W       = 18;
   localparam int CSR_IDX_W   = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_COUNT     = 1'b0,
      CSR_SUM_THRESHOLD = 1'b1
   } csr_index_type;

endpackage

>>> src/pmn_req_if.sv
interface pmn_req_if;
   import pmn_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [PROB_W-1:0] prob_0;
   logic signed [PROB_W-1:0] prob_1;
   logic signed [PROB_W-1:0] prob_2;
   logic signed [PROB_W-1:0] prob_3;
   logic signed [PROB_W-1:0] prob_4;
   logic signed [PROB_W-1:0] prob_5;
   logic signed [PROB_W-1:0] prob_6;
   logic signed [PROB_W-1:0] prob_7;

   modport source (output valid, prob_0, prob_1, prob_2, prob_3, prob_4, prob_5, prob_6,
                   prob_7, input ready);
   modport sink (input valid, prob_0, prob_1, prob_2, prob_3, prob_4, prob_5, prob_6,
                 prob_7, output ready);
endinterface

>>> src/pmn_rsp_if.sv
interface pmn_rsp_if;
   import pmn_pkg::*;

   logic              valid;
   logic              ready;
   logic [NORM_W-1:0] norm_0;
   logic [NORM_W-1:0] norm_1;
   logic [NORM_W-1:0] norm_2;
   logic [NORM_W-1:0] norm_3;
   logic [NORM_W-1:0] norm_4;
   logic [NORM_W-1:0] norm_5;
   logic [NORM_W-1:0] norm_6;
   logic [NORM_W-1:0] norm_7;
   logic              normalized;

   modport source (output valid, norm_0, norm_1, norm_2, norm_3, norm_4, norm_5, norm_6,
                   norm_7, normalized, input ready);
   modport sink (input valid, norm_0, norm_1, norm_2, norm_3, norm_4, norm_5, norm_6,
                 norm_7, normalized, output ready);
endinterface

>>> src/pmn_divider.sv
module pmn_divider (
   input  logic                           clock,
   input  logic                           advance,
   input  logic [pmn_pkg::POS_W-1:0]      pos,
   input  logic [pmn_pkg::SUM_W-1:0]      sum,
   output logic [pmn_pkg::NORM_W-1:0]     quot
);
   import pmn_pkg::*;

   localparam int STEPS = NORM_W;

   logic [SUM_W-1:0]  rem_ff  [STEPS];
   logic [SUM_W-1:0]  rem_in  [STEPS];
   logic [SUM_W-1:0]  div_ff  [STEPS];
   logic [NORM_W-1:0] quot_ff [STEPS];
   logic [NORM_W-1:0] quot_in [STEPS];

   // One quotient bit per stage, restoring long division of pos * 2^15 by sum.
   // pos <= sum, so pos >> 1 is already below the divisor and seeds the remainder.
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [SUM_W-1:0] r_prev;
      logic [SUM_W-1:0] d_prev;
      logic [NORM_W-1:0] q_prev;
      logic              b_in;
      logic [SUM_W:0]    trial;
      logic [SUM_W:0]    diff;

      if (k == 0) begin : g_first
         assign r_prev = SUM_W'(pos[POS_W-1:1]);
         assign d_prev = sum;
         assign q_prev = '0;
         assign b_in   = pos[0];
      end else begin : g_rest
         assign r_prev = rem_ff[k-1];
         assign d_prev = div_ff[k-1];
         assign q_prev = quot_ff[k-1];
         assign b_in   = 1'b0;
      end

      assign trial = {r_prev, b_in};
      assign diff  = trial - {1'b0, d_prev};

      always_comb begin
         if (trial >= {1'b0, d_prev}) begin
            rem_in[k]  = diff[SUM_W-1:0];
            quot_in[k] = {q_prev[NORM_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = trial[SUM_W-1:0];
            quot_in[k] = {q_prev[NORM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in[k];
            div_ff[k]  <= d_prev;
            quot_ff[k] <= quot_in[k];
         end
      end
   end

   assign quot = quot_ff[STEPS-1];

endmodule

>>> src/probability_map_normalizer.sv
// Channel | Dir | Transaction
// req     | in  | one voxel: prob_0..prob_7, signed Q2.14
// rsp     | out | one result: norm_0..norm_7 (unsigned Q1.15) and normalized
// csr     | in  | register write: index 0 map_count, index 1 sum_threshold
//
// One voxel enters per cycle unless rsp stalls; the pipeline is a masking stage, a summing stage,
// then one stage per quotient bit of the 16-stage restoring divider in each map lane.
// Reset is synchronous, active high; it clears valid bits and restores the registers.
// A stall at rsp freezes the whole pipeline in place; nothing is lost or repeated.
module probability_map_normalizer #(
   parameter int MAX_MAPS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   pmn_req_if.sink                       req,
   pmn_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [pmn_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pmn_pkg::CSR_W-1:0]     csr_wdata
);
   import pmn_pkg::*;

   localparam int STEPS = NORM_W;

   // Configuration registers
   logic [COUNT_W-1:0] map_count_ff;
   logic [SUM_W-1:0]   threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_count_ff <= COUNT_W'(FIELD_COUNT);
         threshold_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAP_COUNT:     map_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_SUM_THRESHOLD: threshold_ff <= csr_wdata[SUM_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the map count to the lanes that exist.
   logic [COUNT_W-1:0] used_maps;
   assign used_maps = (map_count_ff > COUNT_W'(MAX_MAPS)) ? COUNT_W'(MAX_MAPS) : map_count_ff;

   logic signed [PROB_W-1:0] prob [FIELD_COUNT];
   assign prob[0] = req.prob_0;
   assign prob[1] = req.prob_1;
   assign prob[2] = req.prob_2;
   assign prob[3] = req.prob_3;
   assign prob[4] = req.prob_4;
   assign prob[5] = req.prob_5;
   assign prob[6] = req.prob_6;
   assign prob[7] = req.prob_7;

   // The whole pipeline moves together; hold everything while the result waits.
   logic advance;
   logic vld_ff [STEPS];
   logic flg_ff [STEPS];

   assign advance   = !vld_ff[STEPS-1] || rsp.ready;
   assign req.ready = advance;

   // Stage A: keep only strictly positive values of used maps.
   logic             va_ff;
   logic [POS_W-1:0] pos_ff [MAX_MAPS];

   for (genvar i = 0; i < MAX_MAPS; i++) begin : g_mask
      always_ff @(posedge clock) begin
         if (advance) begin
            if ((COUNT_W'(i) < used_maps) && (prob[i] > 0)) begin
               pos_ff[i] <= prob[i][POS_W-1:0];
            end else begin
               pos_ff[i] <= '0;
            end
         end
      end
   end

   // Stage B: exact positive sum and the threshold compare.
   logic [SUM_W-1:0] sum_in;
   logic             vb_ff;
   logic             flag_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [POS_W-1:0] posb_ff [MAX_MAPS];

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < MAX_MAPS; i++) begin
         sum_in = sum_in + SUM_W'(pos_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff  <= sum_in;
         flag_ff <= sum_in > threshold_ff;
         posb_ff <= pos_ff;
      end
   end

   // Valid bits, plus the normalized flag riding alongside the divider stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         for (int k = 0; k < STEPS; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         va_ff     <= req.valid;
         vb_ff     <= va_ff;
         vld_ff[0] <= vb_ff;
         for (int k = 1; k < STEPS; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flg_ff[0] <= flag_ff;
         for (int k = 1; k < STEPS; k++) begin
            flg_ff[k] <= flg_ff[k-1];
         end
      end
   end

   // Divider lanes, one per map; drop the quotient when the voxel is not normalized
   // (this also covers a zero sum, where the divider output means nothing).
   logic [NORM_W-1:0] norm [FIELD_COUNT];

   for (genvar i = 0; i < FIELD_COUNT; i++) begin : g_lane
      if (i < MAX_MAPS) begin : g_used
         logic [NORM_W-1:0] quot;

         pmn_divider u_div (
            .clock   (clock),
            .advance (advance),
            .pos     (posb_ff[i]),
            .sum     (sum_ff),
            .quot    (quot)
         );

         assign norm[i] = flg_ff[STEPS-1] ? quot : '0;
      end else begin : g_unused
         assign norm[i] = '0;
      end
   end

   assign rsp.valid      = vld_ff[STEPS-1];
   assign rsp.normalized = flg_ff[STEPS-1];
   assign rsp.norm_0     = norm[0];
   assign rsp.norm_1     = norm[1];
   assign rsp.norm_2     = norm[2];
   assign rsp.norm_3     = norm[3];
   assign rsp.norm_4     = norm[4];
   assign rsp.norm_5     = norm[5];
   assign rsp.norm_6     = norm[6];
   assign rsp.norm_7     = norm[7];

   // A voxel that is not normalized must give zero fractions on norm_0, norm_1 and norm_7.
   a_zero_when_not_norm: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.normalized) |->
         (rsp.norm_0 == '0 && rsp.norm_1 == '0 && rsp.norm_7 == '0))
      else $error("nonzero fraction on a voxel that was not normalized");

   // Fractions norm_0 and norm_1 never exceed 1.0.
   a_fraction_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.norm_0 <= 16'd32768 && rsp.norm_1 <= 16'd32768))
      else $error("fraction above 1.0");

   // A stalled pipeline keeps its first valid bits (va_ff, vb_ff, vld_ff[0]) in place.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(vld_ff[0]) && $stable(va_ff) && $stable(vb_ff)))
      else $error("pipeline moved during a stall");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pmn_pkg::*;

   // One voxel: eight signed Q2.14 map values.
   typedef struct {
      logic signed [PROB_W-1:0] prob [FIELD_COUNT];
   } voxel_type;

   // One normalized result: eight Q1.15 fractions plus the flag.
   typedef struct {
      logic [NORM_W-1:0] norm [FIELD_COUNT];
      logic              normalized;
   } norm_result_type;

   localparam int LATENCY     = 18;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   pmn_req_if req_if ();
   pmn_rsp_if rsp_if ();

   probability_map_normalizer #(.MAX_MAPS(8)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the two registers, updated with every write.
   logic [COUNT_W-1:0] cur_map_count;
   logic [SUM_W-1:0]   cur_threshold;

   norm_result_type expected_norms [$];
   int error_count;
   int voxels_sent;
   int results_seen;
   int normalized_seen;
   int cycle_count;

   // Idle control: 32 percent idling unless a quiet stretch is active.
   bit quiet_stretch;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Hard stop on a hung pipeline.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch #%0d at result %0d: %s got %0d want %0d",
               error_count, results_seen, what, got, want);
      error_count++;
   endtask

   // Compute the expected normalization of one voxel under the current registers.
   function automatic norm_result_type normalize_voxel(input voxel_type v);
      norm_result_type r;
      logic [POS_W-1:0] pos [FIELD_COUNT];
      logic [SUM_W-1:0] sum;
      int used;
      sum  = '0;
      used = (cur_map_count > 8) ? 8 : cur_map_count;
      for (int i = 0; i < FIELD_COUNT; i++) begin
         pos[i] = (i < used && v.prob[i] > 0) ? v.prob[i][POS_W-1:0] : '0;
         sum += pos[i];
         r.norm[i] = '0;
      end
      r.normalized = 1'b0;
      if (sum > cur_threshold) begin
         for (int i = 0; i < FIELD_COUNT; i++)
            r.norm[i] = NORM_W'((longint'(pos[i]) * 32768) / longint'(sum));
         r.normalized = 1'b1;
      end
      return r;
   endfunction

   function automatic bit idle_now();
      return !quiet_stretch && ($urandom_range(99) < 32);
   endfunction

   // Drive one voxel and hold it until the handshake; valid stays high so a
   // following voxel can go out back to back; this task drops it only on an idle cycle.
   task automatic send_voxel(input voxel_type v);
      while (idle_now()) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.prob_0 <= v.prob[0];
      req_if.prob_1 <= v.prob[1];
      req_if.prob_2 <= v.prob[2];
      req_if.prob_3 <= v.prob[3];
      req_if.prob_4 <= v.prob[4];
      req_if.prob_5 <= v.prob[5];
      req_if.prob_6 <= v.prob[6];
      req_if.prob_7 <= v.prob[7];
      expected_norms.push_back(normalize_voxel(v));
      voxels_sent++;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Drop valid, then wait until every expected result has come.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_norms.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // Write a register; only called with the pipeline empty.
   task automatic write_csr(input csr_index_type idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAP_COUNT) cur_map_count = COUNT_W'(value);
      else cur_threshold = SUM_W'(value);
      @(negedge clock);
   endtask

   function automatic voxel_type random_voxel();
      voxel_type v;
      for (int i = 0; i < FIELD_COUNT; i++) begin
         case ($urandom_range(5))
            0: v.prob[i] = PROB_W'($urandom);
            1: v.prob[i] = -PROB_W'($urandom_range(16384));
            2: v.prob[i] = '0;
            3: v.prob[i] = PROB_W'($urandom_range(32767, 32000));
            default: v.prob[i] = PROB_W'($urandom_range(16384));
         endcase
      end
      return v;
   endfunction

   // Check each result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         norm_result_type want;
         logic [NORM_W-1:0] got [FIELD_COUNT];
         got = '{rsp_if.norm_0, rsp_if.norm_1, rsp_if.norm_2, rsp_if.norm_3,
                 rsp_if.norm_4, rsp_if.norm_5, rsp_if.norm_6, rsp_if.norm_7};
         if (expected_norms.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            want = expected_norms.pop_front();
            for (int i = 0; i < FIELD_COUNT; i++)
               if (got[i] !== want.norm[i])
                  report_mismatch($sformatf("norm_%0d", i), got[i], want.norm[i]);
            if (rsp_if.normalized !== want.normalized)
               report_mismatch("normalized", rsp_if.normalized, want.normalized);
            if (want.normalized) normalized_seen++;
         end
         results_seen++;
      end
   end

   // Stall the result side at random.
   always @(negedge clock) begin
      if (!reset) rsp_if.ready <= !idle_now();
   end

   // Extremes, signs, map_count masking, zero sum and the sum threshold.
   task automatic test_directed();
      voxel_type v;
      v.prob = '{default: 16'sh7fff};
      send_voxel(v);
      v.prob = '{default: 16'sh8000};
      send_voxel(v);
      v.prob = '{default: 0};
      send_voxel(v);
      v.prob = '{default: 1};
      send_voxel(v);
      v.prob = '{16'sh7fff, 0, 0, 0, 0, 0, 0, 0};
      send_voxel(v);
      v.prob = '{0, 0, 0, 0, 0, 0, 0, 1};
      send_voxel(v);
      v.prob = '{16384, -16384, 16384, -1, 0, 16'sh8000, 8192, 8192};
      send_voxel(v);
      v.prob = '{16'sh5555, 16'shaaaa, 16'sh2aaa, 16'shd555, 3, 5, 7, 11};
      send_voxel(v);
      wait_drained();
      // Only map 0 in use; other maps must be left out.
      write_csr(CSR_MAP_COUNT, 1);
      v.prob = '{100, 16'sh7fff, 16'sh7fff, 1, 1, 1, 1, 1};
      send_voxel(v);
      v.prob = '{-5, 16'sh7fff, 16'sh7fff, 1, 1, 1, 1, 1};
      send_voxel(v);
      wait_drained();
      // No maps, and counts above the limit that must saturate.
      write_csr(CSR_MAP_COUNT, 0);
      v.prob = '{default: 16'sh7fff};
      send_voxel(v);
      wait_drained();
      write_csr(CSR_MAP_COUNT, 15);
      send_voxel(v);
      wait_drained();
      write_csr(CSR_MAP_COUNT, 8);
      // Sum exactly at and just above the threshold.
      write_csr(CSR_SUM_THRESHOLD, 300);
      v.prob = '{100, 200, 0, 0, 0, 0, 0, 0};
      send_voxel(v);
      v.prob = '{100, 201, 0, 0, 0, 0, 0, 0};
      send_voxel(v);
      wait_drained();
      write_csr(CSR_SUM_THRESHOLD, 262136);
      v.prob = '{default: 16'sh7fff};
      send_voxel(v);
      wait_drained();
      write_csr(CSR_SUM_THRESHOLD, 262143);
      send_voxel(v);
      wait_drained();
   endtask

   // Random voxels across several register settings.
   task automatic test_random_sweep();
      int counts [5] = '{8, 1, 3, 5, 0};
      int thresh [5] = '{0, 16384, 1, 100000, 0};
      for (int phase = 0; phase < 5; phase++) begin
         write_csr(CSR_MAP_COUNT, counts[phase]);
         write_csr(CSR_SUM_THRESHOLD, thresh[phase]);
         quiet_stretch = (phase == 2);
         for (int n = 0; n < 200; n++) send_voxel(random_voxel());
         wait_drained();
      end
      quiet_stretch = 1'b0;
   endtask

   // Random registers and bursts; the sender pauses for a full drain each time.
   task automatic test_random_settings();
      for (int phase = 0; phase < 10; phase++) begin
         write_csr(CSR_MAP_COUNT, $urandom_range(15));
         write_csr(CSR_SUM_THRESHOLD, $urandom_range(3) == 0 ?
                   $urandom_range(262143) : $urandom_range(40000));
         for (int n = 0; n < 45; n++) send_voxel(random_voxel());
         wait_drained();
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_MAP_COUNT;
      csr_wdata     = '0;
      req_if.valid  = 1'b0;
      req_if.prob_0 = '0;
      req_if.prob_1 = '0;
      req_if.prob_2 = '0;
      req_if.prob_3 = '0;
      req_if.prob_4 = '0;
      req_if.prob_5 = '0;
      req_if.prob_6 = '0;
      req_if.prob_7 = '0;
      rsp_if.ready  = 1'b0;
      cur_map_count = 8;
      cur_threshold = '0;
      quiet_stretch = 1'b0;
      error_count     = 0;
      voxels_sent     = 0;
      results_seen    = 0;
      normalized_seen = 0;
      cycle_count     = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_sweep();
      test_random_settings();

      for (int k = 0; k < 10 * LATENCY && expected_norms.size() != 0; k++)
         @(negedge clock);
      if (expected_norms.size() != 0)
         report_mismatch("results never arrived", 0, expected_norms.size());

      $display("covered %0d voxels, %0d results, %0d normalized, all register extremes",
               voxels_sent, results_seen, normalized_seen);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
